// ===== rtl/dq_pkg.sv =====
// Shared constants and types for the double-ended queue.
// Holds the queue depth, request and status codes, and the cell command type.
// Used by dq_cell and double_ended_queue; depends on nothing.
package dq_pkg;

  // Queue geometry
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Request codes
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // What one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,  // keep its word
    CELL_SHIFT_UP   = 2'd1,  // take the word of its front-side neighbor
    CELL_SHIFT_DOWN = 2'd2,  // take the word of its back-side neighbor
    CELL_LOAD       = 2'd3   // take the pushed value
  } cell_op_e;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the queue row: holds one word and trades it with its
// neighbors as the row shifts. Depends on dq_pkg.
module dq_cell
  import dq_pkg::*;
(
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [DATA_W-1:0] up_i,     // neighbor toward the front (push value at cell 0)
  input  logic [DATA_W-1:0] down_i,   // neighbor toward the back
  input  logic [DATA_W-1:0] load_i,   // pushed value
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] data_q, data_d;

  // next word
  always_comb begin
    case (op_i)
      CELL_SHIFT_UP:   data_d = up_i;
      CELL_SHIFT_DOWN: data_d = down_i;
      CELL_LOAD:       data_d = load_i;
      default:         data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values built as a row of shifting cells.
// Top level; depends on dq_pkg and dq_cell.
//
// The queue takes one request in every clock cycle (busy stays low) and
// answers each one in the next cycle with done_o high for a single
// cycle, carrying status, the popped value and the element count after the
// request. The receiver cannot stall, so results must be taken when shown.
// The front element always sits in cell 0 and the row shifts as a whole on
// front pushes and pops, so every request finishes as soon as the
// cell row updates. A push into a full queue (DEPTH entries) reports
// full and a pop from an empty queue reports empty; neither changes the queue.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] pop_value_o,
  output logic [CNT_W-1:0]         element_count_o
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q;
  logic [1:0]        status_q, status_d;
  logic [DATA_W-1:0] pop_q, pop_d;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] back_word;
  logic              is_push, is_full, is_empty, go;

  // the row answers every cycle
  assign busy = 1'b0;

  assign is_push  = (req_type_i == REQ_PUSH_FRONT) || (req_type_i == REQ_PUSH_BACK);
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);
  assign go       = start && (is_push ? !is_full : !is_empty);

  // last live word: one-hot pick over the cells
  always_comb begin
    back_word = '0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (count_q == CNT_W'(i + 1)) back_word = back_word | cell_data[i];
    end
  end

  // status, popped value and next count
  always_comb begin
    status_d = ST_DONE;
    pop_d    = '0;
    count_d  = count_q;
    if (start) begin
      if (is_push && is_full) begin
        status_d = ST_FULL;
      end else if (!is_push && is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        unique case (req_type_i)
          REQ_PUSH_FRONT, REQ_PUSH_BACK: count_d = count_q + CNT_W'(1);
          REQ_POP_FRONT: begin
            pop_d   = cell_data[0];
            count_d = count_q - CNT_W'(1);
          end
          REQ_POP_BACK: begin
            pop_d   = back_word;
            count_d = count_q - CNT_W'(1);
          end
          default: count_d = count_q;
        endcase
      end
    end
  end

  // cell row
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    cell_op_e          op;
    logic [DATA_W-1:0] up_w, down_w;

    if (g == 0) begin : g_first
      assign up_w = push_value_i;
    end else begin : g_mid
      assign up_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign down_w = '0;
    end else begin : g_inner
      assign down_w = cell_data[g+1];
    end

    always_comb begin
      op = CELL_HOLD;
      if (go) begin
        unique case (req_type_i)
          REQ_PUSH_FRONT: op = CELL_SHIFT_UP;
          REQ_POP_FRONT:  op = CELL_SHIFT_DOWN;
          REQ_PUSH_BACK:  op = (count_q == CNT_W'(g)) ? CELL_LOAD : CELL_HOLD;
          default:        op = CELL_HOLD;
        endcase
      end
    end

    dq_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .up_i   (up_w),
      .down_i (down_w),
      .load_i (push_value_i),
      .data_o (cell_data[g])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pop_q    <= pop_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign pop_value_o     = pop_q;
  assign element_count_o = count_q;

  // count never passes the depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("element count above depth");

  // a full report only comes from a full queue
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> count_q == FULL_CNT)
    else $error("full status with room left");

  // an empty report leaves an empty queue and a zero value
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> (count_q == '0) && (pop_value_o == '0))
    else $error("empty status on a non-empty queue");

  // an accepted push into room grows the count by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && is_push && !is_full |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the count");

  // a rejected request leaves the count alone
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !go |=> count_q == $past(count_q))
    else $error("rejected request changed the count");

endmodule
